// ===== design/fclr_pkg.sv =====
// Shared types and constants for the four-channel linear ramp block.
package fclr_pkg;

  localparam int POS_W     = 17;
  localparam int START_W   = 16;
  localparam int LEN_W     = 24;
  localparam int ELAPSED_W = 25;
  localparam int OUT_SLOTS = 4;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  // Command broadcast from the top level to every lane.
  typedef struct packed {
    logic                       go;
    cmd_t                       cmd;
    logic signed [START_W-1:0]  start_position;
    logic signed [START_W-1:0]  end_position;
    logic signed [LEN_W-1:0]    ramp_length;
    logic signed [LEN_W-1:0]    tick_step;
  } lane_cmd_t;

  // Status a lane reports back to the merge stage.
  typedef struct packed {
    logic                     busy;
    logic                     active;
    logic signed [POS_W-1:0]  position;
  } lane_stat_t;

endpackage

// ===== design/fclr_lane.sv =====
// One ramp channel: state, saturating time update, serial divider and multiply.
module fclr_lane #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fclr_pkg::lane_cmd_t  cmd_i,
  input  logic                 sel_i,
  output fclr_pkg::lane_stat_t stat_o
);

  localparam int CW = (FRACTION_BITS > 1) ? $clog2(FRACTION_BITS) : 1;
  localparam int PW = FRACTION_BITS + 18;
  localparam int EW = fclr_pkg::ELAPSED_W;
  localparam int LW = fclr_pkg::LEN_W;
  localparam int XW = fclr_pkg::POS_W;
  localparam int SW = fclr_pkg::START_W;

  typedef enum logic [1:0] {L_IDLE, L_DIV, L_MUL, L_ADD} lane_st_t;

  lane_st_t                   state_r;
  logic signed [EW-1:0]       elapsed_r;
  logic [LW-1:0]              len_r;
  logic signed [SW-1:0]       start_r;
  logic signed [XW-1:0]       delta_r;
  logic signed [XW-1:0]       pos_r;
  logic [EW-1:0]              rem_r;
  logic [FRACTION_BITS-1:0]   q_r;
  logic [CW-1:0]              cnt_r;
  logic signed [PW-1:0]       prod_r;

  logic signed [EW:0]         t_sum;
  logic signed [EW-1:0]       t_sat;
  logic [EW-1:0]              rem2;
  logic                       ge;
  logic signed [EW-1:0]       len_s;

  always_comb begin
    t_sum = {elapsed_r[EW-1], elapsed_r} + (EW+1)'(cmd_i.tick_step);
    if (t_sum > $signed({2'b00, {(EW-1){1'b1}}})) begin
      t_sat = {1'b0, {(EW-1){1'b1}}};
    end else if (t_sum < $signed({2'b11, {(EW-1){1'b0}}})) begin
      t_sat = {1'b1, {(EW-1){1'b0}}};
    end else begin
      t_sat = t_sum[EW-1:0];
    end
    len_s = $signed({1'b0, len_r});
    rem2  = {rem_r[EW-2:0], 1'b0};
    ge    = (rem2 >= {1'b0, len_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= L_IDLE;
      elapsed_r <= '0;
      len_r     <= '0;
      start_r   <= '0;
      delta_r   <= '0;
      pos_r     <= '0;
    end else begin
      unique case (state_r)
        L_IDLE: begin
          if (cmd_i.go) begin
            if (cmd_i.cmd == fclr_pkg::CMD_START) begin
              if (sel_i) begin
                elapsed_r <= '0;
                if (cmd_i.ramp_length > 0) begin
                  len_r   <= cmd_i.ramp_length;
                  start_r <= cmd_i.start_position;
                  delta_r <= XW'(cmd_i.end_position) - XW'(cmd_i.start_position);
                end else begin
                  len_r <= '0;
                end
                pos_r <= XW'(cmd_i.start_position);
              end
            end else if (len_r != '0) begin
              elapsed_r <= t_sat;
              if (t_sat <= 0) begin
                pos_r <= XW'(start_r);
              end else if (t_sat < len_s) begin
                rem_r   <= t_sat;
                q_r     <= '0;
                cnt_r   <= '0;
                state_r <= L_DIV;
              end else begin
                len_r <= '0;
                pos_r <= XW'(start_r) + delta_r;
              end
            end
          end
        end
        L_DIV: begin
          rem_r <= ge ? rem2 - {1'b0, len_r} : rem2;
          q_r   <= {q_r[FRACTION_BITS-2:0], ge};
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(FRACTION_BITS-1)) state_r <= L_MUL;
        end
        L_MUL: begin
          prod_r  <= PW'($signed({1'b0, q_r}) * delta_r);
          state_r <= L_ADD;
        end
        L_ADD: begin
          // arithmetic shift of the product: floor toward minus infinity
          pos_r   <= XW'(start_r) + prod_r[FRACTION_BITS+XW-1:FRACTION_BITS];
          state_r <= L_IDLE;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign stat_o.busy     = (state_r != L_IDLE);
  assign stat_o.active   = (len_r != '0);
  assign stat_o.position = pos_r;

endmodule

// ===== design/four_channel_linear_ramp_top.sv =====
// Four-channel linear ramp generator: lanes per channel plus output merge.
// A start command or a tick that needs no division is registered in the lanes,
// then snapshotted into the output register; a tick that interpolates first
// passes the lane's bit-serial divider, multiply and add states.
// One item is in the lanes at a time; the next is taken while the result waits.
// Reset (rst_n low, synchronous) clears all channel state: every channel idle.
module four_channel_linear_ramp_top #(
  parameter int CHANNELS      = 4,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [1:0]         in_channel,
  input  logic signed [15:0] in_start_position,
  input  logic signed [15:0] in_end_position,
  input  logic signed [23:0] in_ramp_length,
  input  logic signed [23:0] in_tick_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] out_position_0,
  output logic signed [16:0] out_position_1,
  output logic signed [16:0] out_position_2,
  output logic signed [16:0] out_position_3,
  output logic [3:0]         out_active_mask
);

  localparam int XW = fclr_pkg::POS_W;
  localparam int NS = fclr_pkg::OUT_SLOTS;

  fclr_pkg::lane_cmd_t  lane_cmd;
  fclr_pkg::lane_stat_t stat [CHANNELS];
  logic [CHANNELS-1:0]  lane_busy;

  logic                 busy_r;
  logic                 out_valid_r;
  logic signed [XW-1:0] pos_r [NS];
  logic [NS-1:0]        mask_r;
  logic                 in_xfer;
  logic                 done;
  logic                 load;

  // One item in the lanes at a time; output register decouples the far side.
  assign in_stall = busy_r;
  assign in_xfer  = in_valid && !busy_r;

  assign lane_cmd.go             = in_xfer;
  assign lane_cmd.cmd            = fclr_pkg::cmd_t'(in_cmd);
  assign lane_cmd.start_position = in_start_position;
  assign lane_cmd.end_position   = in_end_position;
  assign lane_cmd.ramp_length    = in_ramp_length;
  assign lane_cmd.tick_step      = in_tick_step;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    fclr_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd_i  (lane_cmd),
      .sel_i  (32'(in_channel) == g),
      .stat_o (stat[g])
    );
    assign lane_busy[g] = stat[g].busy;
  end

  // Lanes register the command at the transfer edge, so busy is valid the
  // cycle after; all lanes idle then means the snapshot is ready.
  assign done = busy_r && (lane_busy == '0);
  assign load = done && (!out_valid_r || !out_stall);

  // Merge: snapshot lane positions and active bits into the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) busy_r <= 1'b1;
      else if (load) busy_r <= 1'b0;
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int j = 0; j < NS; j++) begin
        if (j < CHANNELS) begin
          pos_r[j]  <= stat[j].position;
          mask_r[j] <= stat[j].active;
        end else begin
          pos_r[j]  <= '0;
          mask_r[j] <= 1'b0;
        end
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_position_0  = pos_r[0];
  assign out_position_1  = pos_r[1];
  assign out_position_2  = pos_r[2];
  assign out_position_3  = pos_r[3];
  assign out_active_mask = mask_r;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the four-channel linear ramp generator.
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = 4;
  localparam int FRAC = 16;
  localparam logic signed [24:0] ELAPSED_HI = 25'sd16777215;
  localparam logic signed [24:0] ELAPSED_LO = -25'sd16777216;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_cmd;
  logic [1:0] in_channel;
  logic signed [15:0] in_start_position;
  logic signed [15:0] in_end_position;
  logic signed [23:0] in_ramp_length;
  logic signed [23:0] in_tick_step;
  logic out_valid;
  logic out_stall;
  logic signed [16:0] out_position_0;
  logic signed [16:0] out_position_1;
  logic signed [16:0] out_position_2;
  logic signed [16:0] out_position_3;
  logic [3:0] out_active_mask;

  four_channel_linear_ramp_top u_top (.*);

  // One snapshot of all channel outputs.
  typedef struct packed {
    logic signed [16:0] p0;
    logic signed [16:0] p1;
    logic signed [16:0] p2;
    logic signed [16:0] p3;
    logic [3:0] mask;
  } snapshot_t;

  typedef struct {
    fclr_pkg::cmd_t cmd;
    logic [1:0] ch;
    logic signed [15:0] sp;
    logic signed [15:0] ep;
    logic signed [23:0] len;
    logic signed [23:0] step;
    bit has_exp;
    snapshot_t exp_snap;
  } ramp_row_t;

  // Predictor state, one entry per channel.
  logic signed [24:0] ramp_time [NCH];
  logic signed [23:0] ramp_len [NCH];
  logic signed [15:0] ramp_start [NCH];
  logic signed [16:0] ramp_delta [NCH];
  logic signed [16:0] ramp_pos [NCH];

  snapshot_t expected_snaps[$];
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_ticks = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Time limit: worst case is 1220 items plus heavy idling.
  initial begin
    #30ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void predictor_reset();
    for (int c = 0; c < NCH; c++) begin
      ramp_time[c] = '0;
      ramp_len[c] = '0;
      ramp_start[c] = '0;
      ramp_delta[c] = '0;
      ramp_pos[c] = '0;
    end
  endfunction

  // Advance the channel model by one transfer and return the snapshot.
  function automatic snapshot_t predict_ramp(fclr_pkg::cmd_t cmd, logic [1:0] ch,
      logic signed [15:0] sp, logic signed [15:0] ep,
      logic signed [23:0] len, logic signed [23:0] step);
    snapshot_t s;
    longint t, ratio, prod, q;
    if (cmd == fclr_pkg::CMD_START) begin
      ramp_time[ch] = '0;
      if (len > 0) begin
        ramp_len[ch] = len;
        ramp_start[ch] = sp;
        ramp_delta[ch] = 17'(longint'(ep) - longint'(sp));
      end else begin
        ramp_len[ch] = '0;
      end
      ramp_pos[ch] = 17'(sp);
    end else begin
      for (int c = 0; c < NCH; c++) begin
        if (ramp_len[c] != 0) begin
          t = longint'(ramp_time[c]) + longint'(step);
          if (t > longint'(ELAPSED_HI)) t = ELAPSED_HI;
          if (t < longint'(ELAPSED_LO)) t = ELAPSED_LO;
          ramp_time[c] = 25'(t);
          if (t <= 0) begin
            ramp_pos[c] = 17'(ramp_start[c]);
          end else if (t < longint'(ramp_len[c])) begin
            ratio = (t <<< FRAC) / longint'(ramp_len[c]);
            prod = ratio * longint'(ramp_delta[c]);
            q = prod >>> FRAC;
            ramp_pos[c] = 17'(longint'(ramp_start[c]) + q);
          end else begin
            ramp_len[c] = '0;
            ramp_pos[c] = 17'(longint'(ramp_start[c]) + longint'(ramp_delta[c]));
          end
        end
      end
    end
    s.p0 = ramp_pos[0];
    s.p1 = ramp_pos[1];
    s.p2 = ramp_pos[2];
    s.p3 = ramp_pos[3];
    s.mask = '0;
    for (int c = 0; c < NCH; c++) s.mask[c] = (ramp_len[c] != 0);
    return s;
  endfunction

  // Drive one transfer; hold it until accepted. Valid drops only while idling.
  task automatic send_item(fclr_pkg::cmd_t cmd, logic [1:0] ch, logic signed [15:0] sp,
      logic signed [15:0] ep, logic signed [23:0] len, logic signed [23:0] step,
      bit has_exp, snapshot_t exp_snap);
    snapshot_t s;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_channel <= ch;
    in_start_position <= sp;
    in_end_position <= ep;
    in_ramp_length <= len;
    in_tick_step <= step;
    s = predict_ramp(cmd, ch, sp, ep, len, step);
    if (has_exp && s != exp_snap) begin
      $error("directed row: predictor gives %h, table says %h", s, exp_snap);
      errors++;
    end
    expected_snaps.push_back(s);
    if (cmd == fclr_pkg::CMD_TICK) n_ticks++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_item();
    logic [1:0] ch;
    logic signed [23:0] len, step;
    int kind;
    ch = 2'($urandom);
    kind = $urandom_range(99);
    // Mostly short ramps with small positive steps so ramps really progress.
    if (kind < 35) begin
      case ($urandom_range(3))
        0: len = 24'($urandom);
        1: len = -24'sd1 * 24'($urandom_range(1000));
        default: len = 24'($urandom_range(1, 2000));
      endcase
      send_item(fclr_pkg::CMD_START, ch, 16'($urandom), 16'($urandom), len,
                24'($urandom), 0, '0);
    end else begin
      case ($urandom_range(9))
        0: step = 24'($urandom);
        1: step = -24'sd1 * 24'($urandom_range(300));
        2: step = $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
        default: step = 24'($urandom_range(0, 400));
      endcase
      send_item(fclr_pkg::CMD_TICK, ch, 16'($urandom), 16'($urandom), 24'($urandom),
                step, 0, '0);
    end
  endtask

  // Receiver stall: random by percentage, or a forced long hold-off.
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // Result check at each accepted transfer.
  always @(posedge clk) begin
    snapshot_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_recv++;
      if (expected_snaps.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = expected_snaps.pop_front();
        if (out_position_0 !== e.p0) begin
          $error("position_0: expected %0d, got %0d", e.p0, out_position_0); errors++;
        end
        if (out_position_1 !== e.p1) begin
          $error("position_1: expected %0d, got %0d", e.p1, out_position_1); errors++;
        end
        if (out_position_2 !== e.p2) begin
          $error("position_2: expected %0d, got %0d", e.p2, out_position_2); errors++;
        end
        if (out_position_3 !== e.p3) begin
          $error("position_3: expected %0d, got %0d", e.p3, out_position_3); errors++;
        end
        if (out_active_mask !== e.mask) begin
          $error("active_mask: expected %b, got %b", e.mask, out_active_mask); errors++;
        end
      end
    end
  end

  // Directed rows; snapshots typed in only where obvious from reset state.
  ramp_row_t directed[] = '{
    // start with non-positive length right after reset: output = start
    '{fclr_pkg::CMD_START, 2'd0, 16'sh7fff, 16'sh8000, 24'sd0, 24'sd0, 1,
      '{17'sd32767, 17'sd0, 17'sd0, 17'sd0, 4'b0000}},
    '{fclr_pkg::CMD_START, 2'd1, 16'sh8000, 16'sh7fff, -24'sd5, 24'sh7fffff, 1,
      '{17'sd32767, -17'sd32768, 17'sd0, 17'sd0, 4'b0000}},
    // full swing ramps, extremes of length
    '{fclr_pkg::CMD_START, 2'd0, 16'sh8000, 16'sh7fff, 24'sd100, 24'sd0, 1,
      '{-17'sd32768, -17'sd32768, 17'sd0, 17'sd0, 4'b0001}},
    '{fclr_pkg::CMD_START, 2'd1, 16'sh7fff, 16'sh8000, 24'sh7fffff, 24'sd0, 0, '0},
    '{fclr_pkg::CMD_START, 2'd2, 16'sd100, -16'sd100, 24'sd1, 24'sd0, 0, '0},
    '{fclr_pkg::CMD_START, 2'd3, -16'sd1, 16'sd1, 24'sd3, 24'sd0, 0, '0},
    // tick interpolating, with negative deltas exercising floor shift
    '{fclr_pkg::CMD_TICK, 2'd3, 16'sh1234, 16'sh4321, 24'sh555555, 24'sd1, 0, '0},
    '{fclr_pkg::CMD_TICK, 2'd0, 16'sd0, 16'sd0, 24'sd0, 24'sd33, 0, '0},
    // zero and negative steps: the negative steps take elapsed below zero
    '{fclr_pkg::CMD_TICK, 2'd1, 16'sd0, 16'sd0, 24'sd0, 24'sd0, 0, '0},
    '{fclr_pkg::CMD_TICK, 2'd2, 16'sd0, 16'sd0, 24'sd0, -24'sd200, 0, '0},
    '{fclr_pkg::CMD_TICK, 2'd2, 16'sd0, 16'sd0, 24'sd0, 24'sh800000, 0, '0},
    // elapsed saturates at the low limit, then large positive steps end channel 0's ramp
    '{fclr_pkg::CMD_TICK, 2'd0, 16'sd0, 16'sd0, 24'sd0, 24'sh800000, 0, '0},
    '{fclr_pkg::CMD_TICK, 2'd0, 16'sd0, 16'sd0, 24'sd0, 24'sh7fffff, 0, '0},
    '{fclr_pkg::CMD_TICK, 2'd0, 16'sd0, 16'sd0, 24'sd0, 24'sh7fffff, 0, '0},
    '{fclr_pkg::CMD_TICK, 2'd0, 16'sd0, 16'sd0, 24'sd0, 24'sh7fffff, 0, '0},
    // restart a channel with max length and reach the end
    '{fclr_pkg::CMD_START, 2'd1, 16'sh5555, 16'shaaaa, 24'sh7fffff, 24'sd0, 0, '0},
    '{fclr_pkg::CMD_TICK, 2'd1, 16'sd0, 16'sd0, 24'sd0, 24'sh400000, 0, '0},
    '{fclr_pkg::CMD_TICK, 2'd1, 16'sd0, 16'sd0, 24'sd0, 24'sh7fffff, 0, '0},
    // inactive restart keeps old start/delta
    '{fclr_pkg::CMD_START, 2'd3, 16'sd7, 16'sd9, -24'sd1, 24'sd0, 0, '0},
    '{fclr_pkg::CMD_TICK, 2'd3, 16'sd0, 16'sd0, 24'sd0, 24'sd5, 0, '0}
  };

  task automatic drain_and_settle();
    while (expected_snaps.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic random_phase(int count, int ip, int sp);
    idle_pct = ip;
    stall_pct = sp;
    repeat (count) send_random_item();
  endtask

  initial begin
    int wait_cnt;
    rst_n = 0;
    in_valid = 0;
    in_cmd = 0;
    in_channel = 0;
    in_start_position = 0;
    in_end_position = 0;
    in_ramp_length = 0;
    in_tick_step = 0;
    predictor_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed table.
    foreach (directed[i])
      send_item(directed[i].cmd, directed[i].ch, directed[i].sp, directed[i].ep,
                directed[i].len, directed[i].step, directed[i].has_exp,
                directed[i].exp_snap);

    // Random phases: free-running, sender idle, receiver stall, both.
    random_phase(300, 0, 0);
    random_phase(250, 82, 0);
    random_phase(250, 0, 82);
    random_phase(150, 10, 10);

    // Long receiver hold-off while the sender keeps offering: fills the block.
    hold_off = 1;
    fork
      random_phase(20, 0, 0);
      begin
        wait_cnt = 0;
        while (wait_cnt < 400) begin
          @(posedge clk);
          wait_cnt++;
        end
        hold_off = 0;
      end
    join

    random_phase(230, 0, 0);
    in_valid <= 1'b0;

    drain_and_settle();
    $display("Covered %0d transfers in (%0d ticks), %0d results out, %0d mismatches.",
             n_sent, n_ticks, n_recv, errors);
    $display("Idle/stall phases and a long receiver hold-off were exercised.");
    if (errors == 0 && expected_snaps.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
design/fclr_pkg.sv
design/fclr_lane.sv
design/four_channel_linear_ramp_top.sv
tb/testbench.sv
